/* rtl/salloc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_pkg: shared types and constants of the slot allocator
// Slot geometry, command and status codes, register indexes and the
// command bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package salloc_pkg;

	// slot geometry
	localparam int MAX_SLOTS = 4096;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = SLOT_W + 1;

	// register widths
	localparam int CAP_W    = 13;
	localparam int STRIDE_W = 9;
	localparam int ADDR_W   = 64;
	localparam int OFF_W    = SLOT_W + STRIDE_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_CAPACITY = 3'd1,
		REG_STRIDE   = 3'd2,
		REG_CPU_BASE = 3'd3,
		REG_GPU_BASE = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_ACQUIRE   = 2'd0,
		CMD_RELEASE   = 2'd1,
		CMD_TRANSLATE = 2'd2,
		CMD_REBUILD   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_DISABLED  = 3'd2,
		ST_RANGE     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// reset values of the registers
	localparam logic [CAP_W-1:0]    CAPACITY_RST = CAP_W'(MAX_SLOTS);
	localparam logic [STRIDE_W-1:0] STRIDE_RST   = STRIDE_W'(32);

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // take the input beat, read the stack top
		logic execute;  // update state, load the result register
	} dp_cmd_t;

endpackage
`default_nettype wire

/* rtl/salloc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_ctrl: sequencing of the slot allocator
// Two-state machine: take a beat, then execute it once the result
// register is free. Owns the output valid flag.
// ----------------------------------------------------------------------------
module salloc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output salloc_pkg::dp_cmd_t      cmd
);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// result register can take a new beat
	assign out_free    = !out_valid_q || m_tready;
	assign s_tready    = (state_q == IDLE);
	assign m_tvalid    = out_valid_q;
	assign cmd.capture = s_tvalid && (state_q == IDLE);
	assign cmd.execute = (state_q == EXEC) && out_free;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) state_q <= EXEC;
				end
				EXEC: begin
					if (out_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/salloc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salloc_dp: datapath of the slot allocator
// Configuration registers, free stack memory, bump counter, in-use
// count, address offset multiplier and the result register.
// ----------------------------------------------------------------------------
module salloc_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire salloc_pkg::dp_cmd_t                    cmd,
	input  wire logic                                   cfg_we,
	input  wire logic [salloc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [salloc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [1:0]                             cmd_in,
	input  wire logic [salloc_pkg::SLOT_W-1:0]          slot_in,
	output logic [salloc_pkg::SLOT_W-1:0]               slot_out,
	output salloc_pkg::status_t                         status,
	output logic [salloc_pkg::ADDR_W-1:0]               cpu_address,
	output logic [salloc_pkg::ADDR_W-1:0]               gpu_address,
	output logic [salloc_pkg::CNT_W-1:0]                in_use
);

	localparam int SW = salloc_pkg::SLOT_W;
	localparam int CW = salloc_pkg::CNT_W;
	localparam int AW = salloc_pkg::ADDR_W;
	localparam int OW = salloc_pkg::OFF_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(salloc_pkg::MAX_SLOTS);

	// configuration registers
	logic                               enable_q;
	logic [salloc_pkg::CAP_W-1:0]       capacity_q;
	logic [salloc_pkg::STRIDE_W-1:0]    stride_q;
	logic [AW-1:0]                      cpu_base_q;
	logic [AW-1:0]                      gpu_base_q;

	// allocator state
	logic [SW-1:0] stack_mem [salloc_pkg::MAX_SLOTS];
	logic [CW-1:0] free_top_q;
	logic [CW-1:0] next_fresh_q;
	logic [CW-1:0] in_use_q;

	// captured beat
	salloc_pkg::cmd_t cmd_q;
	logic [SW-1:0]    slot_q;
	logic [SW-1:0]    top_rd_q;
	logic [OW-1:0]    off_q;

	// result register
	logic [SW-1:0]       slot_out_q;
	salloc_pkg::status_t status_q;
	logic [AW-1:0]       cpu_addr_q;
	logic [AW-1:0]       gpu_addr_q;

	// next-state values
	logic [CW-1:0]       eff_cap;
	logic [CW-1:0]       top_d;
	logic [CW-1:0]       fresh_d;
	logic [CW-1:0]       in_use_d;
	logic [SW-1:0]       slot_d;
	salloc_pkg::status_t status_d;
	logic [AW-1:0]       cpu_d;
	logic [AW-1:0]       gpu_d;
	logic                push;
	logic [CW-1:0]       top_m1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			capacity_q <= salloc_pkg::CAPACITY_RST;
			stride_q   <= salloc_pkg::STRIDE_RST;
			cpu_base_q <= '0;
			gpu_base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				salloc_pkg::REG_ENABLE:   enable_q   <= cfg_data[0];
				salloc_pkg::REG_CAPACITY: capacity_q <= cfg_data[salloc_pkg::CAP_W-1:0];
				salloc_pkg::REG_STRIDE:   stride_q   <= cfg_data[salloc_pkg::STRIDE_W-1:0];
				salloc_pkg::REG_CPU_BASE: cpu_base_q <= cfg_data;
				salloc_pkg::REG_GPU_BASE: gpu_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture stage: beat fields, stack top read, address offset
	assign top_m1 = free_top_q - CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= salloc_pkg::cmd_t'(cmd_in);
			slot_q   <= slot_in;
			top_rd_q <= stack_mem[top_m1[SW-1:0]];
			off_q    <= OW'(slot_in) * OW'(stride_q);
		end
	end

	// capacity saturates at the stack depth
	assign eff_cap = (CW'(capacity_q) > MAX_CNT) ? MAX_CNT : CW'(capacity_q);

	// execute logic
	always_comb begin
		top_d    = free_top_q;
		fresh_d  = next_fresh_q;
		in_use_d = in_use_q;
		slot_d   = '0;
		status_d = salloc_pkg::ST_OK;
		cpu_d    = '0;
		gpu_d    = '0;
		push     = 1'b0;
		unique case (cmd_q)
			salloc_pkg::CMD_ACQUIRE: begin
				priority if (!enable_q) begin
					status_d = salloc_pkg::ST_DISABLED;
				end else if (free_top_q != '0) begin
					top_d  = top_m1;
					slot_d = top_rd_q;
					if (in_use_q < MAX_CNT) in_use_d = in_use_q + CW'(1);
				end else if (next_fresh_q >= eff_cap) begin
					status_d = salloc_pkg::ST_EXHAUSTED;
				end else begin
					slot_d  = next_fresh_q[SW-1:0];
					fresh_d = next_fresh_q + CW'(1);
					if (in_use_q < MAX_CNT) in_use_d = in_use_q + CW'(1);
				end
			end
			salloc_pkg::CMD_RELEASE: begin
				if (CW'(slot_q) >= eff_cap) begin
					status_d = salloc_pkg::ST_RANGE;
				end else begin
					if (free_top_q < MAX_CNT) begin
						push  = 1'b1;
						top_d = free_top_q + CW'(1);
					end else begin
						status_d = salloc_pkg::ST_FULL;
					end
					if (in_use_q != '0) in_use_d = in_use_q - CW'(1);
				end
			end
			salloc_pkg::CMD_TRANSLATE: begin
				slot_d = slot_q;
				cpu_d  = cpu_base_q + AW'(off_q);
				gpu_d  = gpu_base_q + AW'(off_q);
			end
			salloc_pkg::CMD_REBUILD: begin
				top_d    = '0;
				fresh_d  = '0;
				in_use_d = '0;
			end
			default: ;
		endcase
	end

	// allocator counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q   <= '0;
			next_fresh_q <= '0;
			in_use_q     <= '0;
		end else if (cmd.execute) begin
			free_top_q   <= top_d;
			next_fresh_q <= fresh_d;
			in_use_q     <= in_use_d;
		end
	end

	// free stack push
	always_ff @(posedge clk) begin
		if (cmd.execute && push) begin
			stack_mem[free_top_q[SW-1:0]] <= slot_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			slot_out_q <= slot_d;
			status_q   <= status_d;
			cpu_addr_q <= cpu_d;
			gpu_addr_q <= gpu_d;
		end
	end

	// in-use count is held in the counter, which changes only on execute or reset
	assign slot_out    = slot_out_q;
	assign status      = status_q;
	assign cpu_address = cpu_addr_q;
	assign gpu_address = gpu_addr_q;
	assign in_use      = in_use_q;

endmodule
`default_nettype wire

/* rtl/slot_allocator_free_stack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slot_allocator_free_stack: descriptor slot allocator with a free stack
// Grants slot numbers from a LIFO of freed slots or a bump counter,
// takes released slots back, and translates slots to CPU/GPU addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ stream (kind in s_tuser, slot in s_tdata);
//   every command gives exactly one result beat on the m_ stream with the
//   granted or echoed slot, both addresses and the in-use count in m_tdata
//   and the status code in m_tuser.
//   Registers (enable, capacity, stride, cpu_base, gpu_base) are written
//   through cfg_we/cfg_index/cfg_data while no command is in flight.
//   A command is captured in IDLE, then executed in EXEC once the result
//   register is free, and its result beat becomes valid. No command is
//   taken before the last has executed; the capture step reads the top of
//   the free stack memory (registered read) and forms slot times stride,
//   the execute step updates the stack, counters and result register.
//   The result register frees the input side: the next command is taken
//   while a result waits. If m_tready stays low, the following command
//   waits in the execute step until the result register drains.
//   Reset clears the counters, the stack pointer and the registers to
//   their defaults; the stack memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// command stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [15:0]                          s_tdata,  // slot_in[11:0], zero pad
	input  wire logic [1:0]                           s_tuser,  // cmd[1:0]
	// result stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [159:0]                              m_tdata,  // slot_out[11:0],
	                                                            // cpu_address[75:12],
	                                                            // gpu_address[139:76],
	                                                            // in_use[152:140], zero pad
	output logic [2:0]                                m_tuser,  // status[2:0]
	// configuration
	input  wire logic                                 cfg_we,
	input  wire logic [salloc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [salloc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SW = salloc_pkg::SLOT_W;
	localparam int CW = salloc_pkg::CNT_W;
	localparam int AW = salloc_pkg::ADDR_W;

	salloc_pkg::dp_cmd_t dp_cmd;
	logic [SW-1:0]       slot_out;
	salloc_pkg::status_t status;
	logic [AW-1:0]       cpu_address;
	logic [AW-1:0]       gpu_address;
	logic [CW-1:0]       in_use;

	salloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (dp_cmd)
	);

	salloc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_in      (s_tuser),
		.slot_in     (s_tdata[SW-1:0]),
		.slot_out    (slot_out),
		.status      (status),
		.cpu_address (cpu_address),
		.gpu_address (gpu_address),
		.in_use      (in_use)
	);

	// result beat packing
	assign m_tdata = {7'd0, in_use, gpu_address, cpu_address, slot_out};
	assign m_tuser = status;

	// checks
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command taken while another is in flight");

	a_in_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (in_use <= CW'(salloc_pkg::MAX_SLOTS)))
		else $error("in-use count above slot count");

	a_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status != salloc_pkg::ST_OK) |-> (cpu_address == '0 && gpu_address == '0))
		else $error("address reported on a failed command");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status == salloc_pkg::ST_EXHAUSTED || status == salloc_pkg::ST_DISABLED))
		|-> (slot_out == '0))
		else $error("slot reported on a failed acquire");

endmodule
`default_nettype wire
